// File: hw/rtl/console_cpu_bus_with_sprite_dma_macros.svh
// Assertion macros shared by the console CPU bus RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef CONSOLE_CPU_BUS_WITH_SPRITE_DMA_MACROS_SVH
`define CONSOLE_CPU_BUS_WITH_SPRITE_DMA_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ccb_pkg.sv
// Package for the console CPU bus: types, address map constants and decode.
// Used by ccb_exec, the top module and the testbench; depends on nothing.
`default_nettype none

package ccb_pkg;

    localparam int RAM_BYTES_DEF = 2048;
    localparam int CPU_RAM_SPAN  = 8192;
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 56;

    localparam logic [15:0] RAM_TOP       = 16'h1FFF;
    localparam logic [15:0] PPU_BASE      = 16'h2000;
    localparam logic [15:0] PPU_TOP       = 16'h3FFF;
    localparam logic [15:0] DMA_PAGE_ADDR = 16'h4014;
    localparam logic [15:0] PAD0_ADDR     = 16'h4016;
    localparam logic [15:0] PAD1_ADDR     = 16'h4017;
    localparam logic [7:0]  PAD_MSB       = 8'h80;
    localparam logic [2:0]  PHASE_LAST    = 3'd5;
    localparam logic [2:0]  PHASE_A       = 3'd0;
    localparam logic [2:0]  PHASE_B       = 3'd3;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_CART = 3'd1,
        TGT_RAM  = 3'd2,
        TGT_PPU  = 3'd3,
        TGT_PAD  = 3'd4,
        TGT_DMA  = 3'd5
    } t_target;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        read_only;
        logic        cart_hit;
        logic [7:0]  cart_data;
        logic [7:0]  ppu_data;
        logic [7:0]  pad0_buttons;
        logic [7:0]  pad1_buttons;
        logic        nmi_pending;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        t_target     target;
        logic [2:0]  ppu_register;
        logic        cpu_step;
        logic        ppu_tick;
        logic        dma_fetch;
        logic [15:0] dma_address;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        cpu_nmi;
        logic        reset_strobe;
    } t_result;

    // Priority decode of a bus address; the page register only answers writes.
    function automatic t_target f_decode(input logic [15:0] addr, input logic hit,
                                         input logic is_write);
        t_target tgt;
        begin
            tgt = TGT_NONE;
            if (hit) begin
                tgt = TGT_CART;
            end else if (addr inside {[16'h0000:RAM_TOP]}) begin
                tgt = TGT_RAM;
            end else if (addr inside {[PPU_BASE:PPU_TOP]}) begin
                tgt = TGT_PPU;
            end else if (is_write && addr == DMA_PAGE_ADDR) begin
                tgt = TGT_DMA;
            end else if (addr inside {PAD0_ADDR, PAD1_ADDR}) begin
                tgt = TGT_PAD;
            end
            return tgt;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ccb_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module ccb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ccb_exec.sv
// Execute stage of the console CPU bus: decode, controller shifters, DMA and phase.
// Depends on ccb_pkg; drives the work RAM write port and read address.
`default_nettype none

module ccb_exec #(
    parameter int RAM_BYTES = ccb_pkg::RAM_BYTES_DEF,
    localparam int AW = $clog2(RAM_BYTES)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire ccb_pkg::t_item  i_new,
    input  wire ccb_pkg::t_item  i_cur,
    input  wire logic [7:0]      i_ram_rdata,
    output logic      [AW-1:0]   o_rd_idx,
    output logic                 o_wr_en,
    output logic      [AW-1:0]   o_wr_idx,
    output logic      [7:0]      o_wr_data,
    output ccb_pkg::t_result     o_result
);

    localparam int MOD_STEPS = (ccb_pkg::CPU_RAM_SPAN + RAM_BYTES - 1) / RAM_BYTES - 1;

    logic [7:0] r_pad [2];
    logic [7:0] r_page;
    logic [7:0] r_index;
    logic [7:0] r_byte;
    logic       r_active;
    logic       r_wait;
    logic [2:0] r_phase;

    logic [7:0] n_pad [2];
    logic [7:0] n_page;
    logic [7:0] n_index;
    logic [7:0] n_byte;
    logic       n_active;
    logic       n_wait;
    logic [2:0] n_phase;

    logic [15:0]      src_addr;
    logic [15:0]      new_rd_addr;
    logic [15:0]      rd_addr;
    ccb_pkg::t_target rd_tgt;
    ccb_pkg::t_target wr_tgt;
    logic [7:0]       rd_byte;

    function automatic logic [AW-1:0] f_ram_idx(input logic [12:0] a);
        logic [13:0] v;
        begin
            v = {1'b0, a};
            for (int k = 0; k < MOD_STEPS; k++) begin
                if (v >= 14'(RAM_BYTES)) begin
                    v = v - 14'(RAM_BYTES);
                end
            end
            return v[AW-1:0];
        end
    endfunction

    assign src_addr    = {r_page, r_index};
    assign new_rd_addr = (i_new.op == ccb_pkg::OP_TICK) ? src_addr : i_new.address;
    assign o_rd_idx    = f_ram_idx(new_rd_addr[12:0]);
    assign rd_addr     = (i_cur.op == ccb_pkg::OP_TICK) ? src_addr : i_cur.address;
    assign rd_tgt      = ccb_pkg::f_decode(rd_addr, i_cur.cart_hit, 1'b0);
    assign wr_tgt      = ccb_pkg::f_decode(i_cur.address, i_cur.cart_hit, 1'b1);
    assign o_wr_idx    = f_ram_idx(i_cur.address[12:0]);
    assign o_wr_data   = i_cur.write_data;

    always_comb begin
        case (rd_tgt)
            ccb_pkg::TGT_CART: rd_byte = i_cur.cart_data;
            ccb_pkg::TGT_RAM:  rd_byte = i_ram_rdata;
            ccb_pkg::TGT_PPU:  rd_byte = i_cur.ppu_data;
            ccb_pkg::TGT_PAD:  rd_byte = {7'd0, (r_pad[rd_addr[0]] & ccb_pkg::PAD_MSB) != 8'd0};
            default:           rd_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_pad    = r_pad;
        n_page   = r_page;
        n_index  = r_index;
        n_byte   = r_byte;
        n_active = r_active;
        n_wait   = r_wait;
        n_phase  = r_phase;
        o_wr_en  = 1'b0;
        o_result = '0;
        case (i_cur.op)
            ccb_pkg::OP_READ: begin
                o_result.read_data = rd_byte;
                o_result.target    = rd_tgt;
                if (rd_tgt == ccb_pkg::TGT_PPU) begin
                    o_result.ppu_register = rd_addr[2:0];
                end
                if (rd_tgt == ccb_pkg::TGT_PAD) begin
                    n_pad[rd_addr[0]] = {r_pad[rd_addr[0]][6:0], 1'b0};
                end
            end
            ccb_pkg::OP_WRITE: begin
                o_result.target = wr_tgt;
                case (wr_tgt)
                    ccb_pkg::TGT_RAM: begin
                        o_wr_en = 1'b1;
                    end
                    ccb_pkg::TGT_PPU: begin
                        o_result.ppu_register = i_cur.address[2:0];
                    end
                    ccb_pkg::TGT_DMA: begin
                        n_page   = i_cur.write_data;
                        n_index  = 8'd0;
                        n_active = 1'b1;
                    end
                    ccb_pkg::TGT_PAD: begin
                        n_pad[i_cur.address[0]] = i_cur.address[0] ? i_cur.pad1_buttons
                                                                   : i_cur.pad0_buttons;
                    end
                    default: begin
                    end
                endcase
            end
            ccb_pkg::OP_TICK: begin
                o_result.ppu_tick = 1'b1;
                o_result.cpu_nmi  = i_cur.nmi_pending;
                if (r_phase == ccb_pkg::PHASE_A || r_phase == ccb_pkg::PHASE_B) begin
                    if (!r_active) begin
                        o_result.cpu_step = 1'b1;
                    end else if (r_wait) begin
                        if (r_phase[0]) begin
                            n_wait = 1'b0;
                        end
                    end else if (!r_phase[0]) begin
                        n_byte             = rd_byte;
                        o_result.read_data = rd_byte;
                        o_result.target    = rd_tgt;
                        o_result.dma_fetch = 1'b1;
                        if (rd_tgt == ccb_pkg::TGT_PPU) begin
                            o_result.ppu_register = rd_addr[2:0];
                        end
                        if (rd_tgt == ccb_pkg::TGT_PAD) begin
                            n_pad[rd_addr[0]] = {r_pad[rd_addr[0]][6:0], 1'b0};
                        end
                    end else begin
                        o_result.oam_write = 1'b1;
                        o_result.oam_index = r_index;
                        o_result.oam_data  = r_byte;
                        n_index            = r_index + 8'd1;
                        if (r_index == 8'hFF) begin
                            n_active = 1'b0;
                            n_wait   = 1'b1;
                        end
                    end
                end
                n_phase = (r_phase == ccb_pkg::PHASE_LAST) ? 3'd0 : r_phase + 3'd1;
            end
            default: begin
                o_result.reset_strobe = 1'b1;
                n_phase               = 3'd0;
            end
        endcase
        o_result.dma_address = {n_page, n_index};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad[0] <= 8'd0;
            r_pad[1] <= 8'd0;
            r_page   <= 8'd0;
            r_index  <= 8'd0;
            r_byte   <= 8'd0;
            r_active <= 1'b0;
            r_wait   <= 1'b1;
            r_phase  <= 3'd0;
        end else if (i_fire) begin
            r_pad    <= n_pad;
            r_page   <= n_page;
            r_index  <= n_index;
            r_byte   <= n_byte;
            r_active <= n_active;
            r_wait   <= n_wait;
            r_phase  <= n_phase;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/console_cpu_bus_with_sprite_dma.sv
// Console CPU bus with sprite DMA: stream handshake, item register, output register.
// Depends on ccb_pkg, ccb_ram, ccb_exec and the assertion macro header.
//
// Usage: each transaction on the slave stream is one bus item. tuser carries the
// operation (read, write, system tick, reset); tdata carries the address, write byte
// and the answers of the cartridge, picture unit and controllers. Each item gives
// exactly one result transaction on the master stream: tuser carries the decoded
// target, tdata the read byte, step strobes, DMA address and sprite memory write.
// The work RAM is read at the clock edge that accepts an item; then, in the execute
// state, the item is executed and its result loaded into the output register once
// that register is free. No new item is accepted while one is in the execute state,
// since the registered read of the work RAM lies ahead of the execute step.
// A new item is accepted while the previous result still waits in the output
// register; if the receiver stalls, execution of that new item holds until the
// register drains. Reset clears the controller shifters, DMA state and tick phase;
// the work RAM content is undefined until written and needs no clearing.
`default_nettype none

`include "console_cpu_bus_with_sprite_dma_macros.svh"

module console_cpu_bus_with_sprite_dma #(
    parameter int RAM_BYTES = ccb_pkg::RAM_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // address, write_data, read_only, cart_hit, cart_data, ppu_data,
    // pad0_buttons, pad1_buttons, nmi_pending
    input  wire logic [ccb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  wire logic [1:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // read_data, ppu_register, cpu_step, ppu_tick, dma_fetch, dma_address,
    // oam_write, oam_index, oam_data, cpu_nmi, reset_strobe
    output logic      [ccb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // target
    output logic      [2:0]                     m_axis_tuser
);

    localparam int AW = $clog2(RAM_BYTES);

    ccb_pkg::t_state  r_state;
    ccb_pkg::t_state  n_state;
    ccb_pkg::t_item   new_item;
    ccb_pkg::t_item   r_item;
    ccb_pkg::t_result result;
    ccb_pkg::t_result r_out;
    logic             r_out_valid;
    logic             accept;
    logic             fire;
    logic [AW-1:0]    rd_idx;
    logic             wr_en;
    logic [AW-1:0]    wr_idx;
    logic [7:0]       wr_data;
    logic [7:0]       ram_rdata;

    assign new_item.op           = ccb_pkg::t_op'(s_axis_tuser);
    assign new_item.address      = s_axis_tdata[15:0];
    assign new_item.write_data   = s_axis_tdata[23:16];
    assign new_item.read_only    = s_axis_tdata[24];
    assign new_item.cart_hit     = s_axis_tdata[25];
    assign new_item.cart_data    = s_axis_tdata[33:26];
    assign new_item.ppu_data     = s_axis_tdata[41:34];
    assign new_item.pad0_buttons = s_axis_tdata[49:42];
    assign new_item.pad1_buttons = s_axis_tdata[57:50];
    assign new_item.nmi_pending  = s_axis_tdata[58];

    assign s_axis_tready = (r_state == ccb_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = (r_state == ccb_pkg::ST_EXEC) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ccb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = ccb_pkg::ST_EXEC;
                end
            end
            ccb_pkg::ST_EXEC: begin
                if (fire) begin
                    n_state = ccb_pkg::ST_IDLE;
                end
            end
            default: n_state = ccb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= new_item;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    ccb_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en && fire),
        .i_waddr (wr_idx),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    ccb_exec #(
        .RAM_BYTES (RAM_BYTES)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_new       (new_item),
        .i_cur       (r_item),
        .i_ram_rdata (ram_rdata),
        .o_rd_idx    (rd_idx),
        .o_wr_en     (wr_en),
        .o_wr_idx    (wr_idx),
        .o_wr_data   (wr_data),
        .o_result    (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.target;
    assign m_axis_tdata  = {7'd0, r_out.reset_strobe, r_out.cpu_nmi, r_out.oam_data,
                            r_out.oam_index, r_out.oam_write, r_out.dma_address,
                            r_out.dma_fetch, r_out.ppu_tick, r_out.cpu_step,
                            r_out.ppu_register, r_out.read_data};

    `CCB_ASSERT_NEXT(a_accept_executes, i_clk, i_rst_n, accept, r_state == ccb_pkg::ST_EXEC, "Accepted transaction did not reach execute.")
    `CCB_ASSERT_SAME(a_no_ram_overlap, i_clk, i_rst_n, wr_en && fire, !accept, "Work RAM written while a new transaction is read.")
    `CCB_ASSERT_NEXT(a_fire_offers_result, i_clk, i_rst_n, fire, m_axis_tvalid && s_axis_tready, "Executed transaction produced no result.")

endmodule

`default_nettype wire

// File: tb/console_cpu_bus_with_sprite_dma_tb.sv
// Self-checking testbench for the console CPU bus with sprite DMA: directed and random
// bus items with random idling on both streams, checked against a cycle-free predictor.
// Depends on ccb_pkg and the console_cpu_bus_with_sprite_dma RTL.
`timescale 1ns / 100ps

module console_cpu_bus_with_sprite_dma_tb;

    localparam int STALL_LIMIT = 3000;

    typedef struct {
        ccb_pkg::t_item item;
        bit             hold;
    } bus_job;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // address, write_data, read_only, cart_hit, cart_data, ppu_data,
    // pad0_buttons, pad1_buttons, nmi_pending
    logic [ccb_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // operation
    logic [1:0]                     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // read_data, ppu_register, cpu_step, ppu_tick, dma_fetch, dma_address,
    // oam_write, oam_index, oam_data, cpu_nmi, reset_strobe
    logic [ccb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // target
    logic [2:0]                     m_axis_tuser;

    // Predicted state of the bus.
    logic [7:0]  ram_img [0:2047];
    bit          ram_valid [0:2047];
    logic [7:0]  pad_sr [0:1];
    logic [7:0]  page_img = '0;
    logic [7:0]  dma_idx = '0;
    logic [7:0]  dma_latch = '0;
    logic        dma_on = 1'b0;
    logic        dma_waiting = 1'b1;
    logic [2:0]  phase = '0;

    bus_job           pending[$];
    ccb_pkg::t_result results_due[$];
    ccb_pkg::t_item   cur_item;
    int               gap_left = 0;
    int               stall_left = 0;
    int               items_taken = 0;
    int               total_items = 0;
    int               results_seen = 0;
    int               faults = 0;
    int               idle_cycles = 0;

    console_cpu_bus_with_sprite_dma dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] fetch_byte(input logic [15:0] addr,
                                              input ccb_pkg::t_item it,
                                              output ccb_pkg::t_target tgt,
                                              output logic [2:0] preg);
        logic [7:0] val;
        tgt = ccb_pkg::TGT_NONE;
        preg = '0;
        val = '0;
        if (it.cart_hit) begin
            tgt = ccb_pkg::TGT_CART;
            val = it.cart_data;
        end else if (addr <= ccb_pkg::RAM_TOP) begin
            tgt = ccb_pkg::TGT_RAM;
            val = ram_img[addr[10:0]];
        end else if (addr >= ccb_pkg::PPU_BASE && addr <= ccb_pkg::PPU_TOP) begin
            tgt = ccb_pkg::TGT_PPU;
            preg = addr[2:0];
            val = it.ppu_data;
        end else if (addr == ccb_pkg::PAD0_ADDR || addr == ccb_pkg::PAD1_ADDR) begin
            tgt = ccb_pkg::TGT_PAD;
            val = {7'b0, pad_sr[addr[0]][7]};
            pad_sr[addr[0]] = pad_sr[addr[0]] << 1;
        end
        return val;
    endfunction

    function automatic ccb_pkg::t_result bus_step(input ccb_pkg::t_item it);
        ccb_pkg::t_result r;
        ccb_pkg::t_target tgt;
        logic [2:0]       preg;
        r = '0;
        case (it.op)
            ccb_pkg::OP_READ: begin
                r.read_data = fetch_byte(it.address, it, tgt, preg);
                r.target = tgt;
                r.ppu_register = preg;
            end
            ccb_pkg::OP_WRITE: begin
                if (it.cart_hit) begin
                    r.target = ccb_pkg::TGT_CART;
                end else if (it.address <= ccb_pkg::RAM_TOP) begin
                    r.target = ccb_pkg::TGT_RAM;
                    ram_img[it.address[10:0]] = it.write_data;
                    ram_valid[it.address[10:0]] = 1'b1;
                end else if (it.address >= ccb_pkg::PPU_BASE
                             && it.address <= ccb_pkg::PPU_TOP) begin
                    r.target = ccb_pkg::TGT_PPU;
                    r.ppu_register = it.address[2:0];
                end else if (it.address == ccb_pkg::DMA_PAGE_ADDR) begin
                    r.target = ccb_pkg::TGT_DMA;
                    page_img = it.write_data;
                    dma_idx = '0;
                    dma_on = 1'b1;
                end else if (it.address == ccb_pkg::PAD0_ADDR
                             || it.address == ccb_pkg::PAD1_ADDR) begin
                    r.target = ccb_pkg::TGT_PAD;
                    pad_sr[it.address[0]] = it.address[0] ? it.pad1_buttons
                                                          : it.pad0_buttons;
                end
            end
            ccb_pkg::OP_TICK: begin
                r.ppu_tick = 1'b1;
                if (phase == ccb_pkg::PHASE_A || phase == ccb_pkg::PHASE_B) begin
                    if (!dma_on) begin
                        r.cpu_step = 1'b1;
                    end else if (dma_waiting) begin
                        if (phase[0])
                            dma_waiting = 1'b0;
                    end else if (!phase[0]) begin
                        dma_latch = fetch_byte({page_img, dma_idx}, it, tgt, preg);
                        r.read_data = dma_latch;
                        r.target = tgt;
                        r.ppu_register = preg;
                        r.dma_fetch = 1'b1;
                    end else begin
                        r.oam_write = 1'b1;
                        r.oam_index = dma_idx;
                        r.oam_data = dma_latch;
                        dma_idx = dma_idx + 8'd1;
                        if (dma_idx == 8'd0) begin
                            dma_on = 1'b0;
                            dma_waiting = 1'b1;
                        end
                    end
                end
                r.cpu_nmi = it.nmi_pending;
                phase = (phase == ccb_pkg::PHASE_LAST) ? 3'd0 : phase + 3'd1;
            end
            default: begin
                r.reset_strobe = 1'b1;
                phase = '0;
            end
        endcase
        r.dma_address = {page_img, dma_idx};
        return r;
    endfunction

    // Work RAM that has never been written must not be read, so such reads are handed
    // to the cartridge instead.
    function automatic ccb_pkg::t_item claim_unwritten(input ccb_pkg::t_item it);
        logic [15:0] src;
        logic        reads_ram;
        src = it.address;
        reads_ram = (it.op == ccb_pkg::OP_READ);
        if (it.op == ccb_pkg::OP_TICK) begin
            src = {page_img, dma_idx};
            reads_ram = dma_on && !dma_waiting && phase == ccb_pkg::PHASE_A;
        end
        if (reads_ram && !it.cart_hit && src <= ccb_pkg::RAM_TOP && !ram_valid[src[10:0]])
            it.cart_hit = 1'b1;
        return it;
    endfunction

    function automatic int pick_gap(input int count);
        int r;
        if ((count / 120) % 5 == 4)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ccb_pkg::t_item bus_item(input ccb_pkg::t_op op,
                                                input logic [15:0] addr,
                                                input logic [7:0] wdata);
        ccb_pkg::t_item it;
        it.op = op;
        it.address = addr;
        it.write_data = wdata;
        it.read_only = 1'($urandom);
        it.cart_hit = 1'b0;
        it.cart_data = 8'($urandom);
        it.ppu_data = 8'($urandom);
        it.pad0_buttons = 8'($urandom);
        it.pad1_buttons = 8'($urandom);
        it.nmi_pending = 1'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 16'(($urandom_range(0, 3) << 11) | $urandom_range(0, 63));
        if (r < 40)
            return 16'($urandom_range(0, 16'h1FFF));
        if (r < 60)
            return 16'($urandom_range(16'h2000, 16'h3FFF));
        if (r < 68)
            return ccb_pkg::DMA_PAGE_ADDR;
        if (r < 80)
            return $urandom_range(0, 1) ? ccb_pkg::PAD1_ADDR : ccb_pkg::PAD0_ADDR;
        return 16'($urandom);
    endfunction

    function automatic ccb_pkg::t_item random_item();
        ccb_pkg::t_item it;
        ccb_pkg::t_op   op;
        int             r;
        r = $urandom_range(0, 99);
        if (r < 30)
            op = ccb_pkg::OP_READ;
        else if (r < 60)
            op = ccb_pkg::OP_WRITE;
        else if (r < 95)
            op = ccb_pkg::OP_TICK;
        else
            op = ccb_pkg::OP_RESET;
        it = bus_item(op, pick_address(), 8'($urandom));
        it.cart_hit = ($urandom_range(0, 99) < 15);
        return it;
    endfunction

    task automatic queue_item(input ccb_pkg::t_item it, input bit hold);
        bus_job job;
        job.item = it;
        job.hold = hold;
        pending.push_back(job);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            faults++;
            if (faults <= 10)
                $display("Mismatch on result %0d, %s: expected %0h, got %0h",
                         results_seen, name, want, got);
        end
    endtask

    initial begin
        ccb_pkg::t_item d;
        ccb_pkg::t_item t;
        for (int i = 0; i < 2048; i++) begin
            ram_img[i] = '0;
            ram_valid[i] = 1'b0;
        end
        pad_sr[0] = '0;
        pad_sr[1] = '0;

        queue_item(bus_item(ccb_pkg::OP_WRITE, 16'h0000, 8'hFF), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_WRITE, 16'h07FF, 8'hA5), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_READ, 16'h1FFF, 8'h00), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_READ, 16'h0800, 8'h00), 1'b0);
        d = bus_item(ccb_pkg::OP_READ, ccb_pkg::PPU_BASE, 8'h00);
        d.ppu_data = 8'hFF;
        queue_item(d, 1'b0);
        d = bus_item(ccb_pkg::OP_READ, ccb_pkg::PPU_TOP, 8'h00);
        d.ppu_data = 8'h00;
        queue_item(d, 1'b0);
        queue_item(bus_item(ccb_pkg::OP_WRITE, 16'h2005, 8'h3C), 1'b0);
        d = bus_item(ccb_pkg::OP_READ, 16'hFFFF, 8'h00);
        d.cart_hit = 1'b1;
        d.cart_data = 8'hFF;
        queue_item(d, 1'b0);
        d = bus_item(ccb_pkg::OP_WRITE, ccb_pkg::DMA_PAGE_ADDR, 8'h12);
        d.cart_hit = 1'b1;
        queue_item(d, 1'b0);
        queue_item(bus_item(ccb_pkg::OP_READ, ccb_pkg::DMA_PAGE_ADDR, 8'h00), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_WRITE, 16'h5000, 8'hFF), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_READ, 16'hFFFF, 8'h00), 1'b0);
        d = bus_item(ccb_pkg::OP_WRITE, ccb_pkg::PAD0_ADDR, 8'h00);
        d.pad0_buttons = 8'hA5;
        queue_item(d, 1'b0);
        d = bus_item(ccb_pkg::OP_WRITE, ccb_pkg::PAD1_ADDR, 8'h00);
        d.pad1_buttons = 8'h5A;
        queue_item(d, 1'b0);
        queue_item(bus_item(ccb_pkg::OP_READ, ccb_pkg::PAD0_ADDR, 8'h00), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_READ, ccb_pkg::PAD0_ADDR, 8'h00), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_READ, ccb_pkg::PAD1_ADDR, 8'h00), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_WRITE, ccb_pkg::DMA_PAGE_ADDR, 8'h40), 1'b0);
        for (int i = 0; i < 6; i++)
            queue_item(bus_item(ccb_pkg::OP_TICK, 16'($urandom), 8'($urandom)), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_WRITE, ccb_pkg::DMA_PAGE_ADDR, 8'h00), 1'b0);
        queue_item(bus_item(ccb_pkg::OP_RESET, 16'($urandom), 8'($urandom)), 1'b0);
        for (int i = 0; i < 2; i++) begin
            d = bus_item(ccb_pkg::OP_TICK, 16'($urandom), 8'($urandom));
            d.nmi_pending = 1'b1;
            queue_item(d, 1'b0);
        end

        for (int i = 0; i < 70; i++)
            queue_item(random_item(), $urandom_range(0, 99) == 0);

        // One complete sprite transfer, started from an idle block.
        case ($urandom_range(0, 2))
            0: d = bus_item(ccb_pkg::OP_WRITE, ccb_pkg::DMA_PAGE_ADDR,
                            8'($urandom_range(0, 7)));
            1: d = bus_item(ccb_pkg::OP_WRITE, ccb_pkg::DMA_PAGE_ADDR, 8'h40);
            default: d = bus_item(ccb_pkg::OP_WRITE, ccb_pkg::DMA_PAGE_ADDR, 8'($urandom));
        endcase
        queue_item(d, 1'b1);
        for (int i = 0; i < 1560; i++) begin
            if ($urandom_range(0, 99) < 5) begin
                t = random_item();
                if (t.op == ccb_pkg::OP_WRITE && t.address == ccb_pkg::DMA_PAGE_ADDR)
                    t.address = 16'h4015;
                queue_item(t, 1'b0);
            end
            t = bus_item(ccb_pkg::OP_TICK, 16'($urandom), 8'($urandom));
            t.cart_hit = ($urandom_range(0, 99) < 20);
            queue_item(t, 1'b0);
        end

        for (int i = 0; i < 20; i++)
            queue_item(random_item(), $urandom_range(0, 99) == 0);
        total_items = pending.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do
            @(posedge i_clk);
        while (items_taken != total_items || results_due.size() != 0);
        repeat (20) @(posedge i_clk);
        if (faults == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        bus_job job;
        logic   drive;
        if (i_rst_n) begin
            drive = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                results_due.push_back(bus_step(cur_item));
                items_taken++;
                drive = 1'b0;
                gap_left = pick_gap(items_taken);
            end
            if (!drive) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0
                             && !(pending[0].hold && results_due.size() != 0)) begin
                    job = pending.pop_front();
                    cur_item = claim_unwritten(job.item);
                    s_axis_tdata <= {5'b0, cur_item.nmi_pending, cur_item.pad1_buttons,
                                     cur_item.pad0_buttons, cur_item.ppu_data,
                                     cur_item.cart_data, cur_item.cart_hit,
                                     cur_item.read_only, cur_item.write_data,
                                     cur_item.address};
                    s_axis_tuser <= cur_item.op;
                    drive = 1'b1;
                end
            end
            s_axis_tvalid <= drive;
        end
    end

    always @(posedge i_clk) begin
        ccb_pkg::t_result want;
        ccb_pkg::t_result got;
        logic             rdy;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '0;
                got.read_data    = m_axis_tdata[7:0];
                got.target       = ccb_pkg::t_target'(m_axis_tuser);
                got.ppu_register = m_axis_tdata[10:8];
                got.cpu_step     = m_axis_tdata[11];
                got.ppu_tick     = m_axis_tdata[12];
                got.dma_fetch    = m_axis_tdata[13];
                got.dma_address  = m_axis_tdata[29:14];
                got.oam_write    = m_axis_tdata[30];
                got.oam_index    = m_axis_tdata[38:31];
                got.oam_data     = m_axis_tdata[46:39];
                got.cpu_nmi      = m_axis_tdata[47];
                got.reset_strobe = m_axis_tdata[48];
                if (results_due.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("Unexpected result transaction: tdata %0h, tuser %0h",
                                 m_axis_tdata, m_axis_tuser);
                end else begin
                    want = results_due.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("target", want.target, got.target);
                    check_field("ppu_register", want.ppu_register, got.ppu_register);
                    check_field("cpu_step", want.cpu_step, got.cpu_step);
                    check_field("ppu_tick", want.ppu_tick, got.ppu_tick);
                    check_field("dma_fetch", want.dma_fetch, got.dma_fetch);
                    check_field("dma_address", want.dma_address, got.dma_address);
                    check_field("oam_write", want.oam_write, got.oam_write);
                    check_field("oam_index", want.oam_index, got.oam_index);
                    check_field("oam_data", want.oam_data, got.oam_data);
                    check_field("cpu_nmi", want.cpu_nmi, got.cpu_nmi);
                    check_field("reset_strobe", want.reset_strobe, got.reset_strobe);
                end
                results_seen++;
                stall_left = pick_gap(results_seen);
            end
            rdy = (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
            m_axis_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ccb_pkg.sv
hw/rtl/ccb_ram.sv
hw/rtl/ccb_exec.sv
hw/rtl/console_cpu_bus_with_sprite_dma.sv
tb/console_cpu_bus_with_sprite_dma_tb.sv
